// File: rtl/text_console_writer_unit_defines.svh
// Assertion macros shared by the text console writer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer: assertion failed");

`endif

// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; used by front, queue, back and top level.
`default_nettype none

package tcw_pkg;

    // command codes on the input tuser
    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_SETCUR = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [15:0] BLANK_CELL   = 16'h0020;   // space, black attribute

    // classified command as handed from front to back
    typedef enum logic [2:0] {
        K_PUT,
        K_NEWLINE,
        K_SETCUR,
        K_CLEAR,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [7:0] col;    // already saturated to COLUMNS-1
        logic [7:0] row;    // already saturated to ROWS-1
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/tcw_front.sv
// Front end: takes input transactions, classifies them and saturates the cursor.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_cmd,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [7:0]    i_attr,
    input  wire logic [7:0]    i_col,
    input  wire logic [7:0]    i_row,
    input  wire logic          i_full,
    input  wire logic          i_hold,
    output logic               o_push,
    output tcw_pkg::t_cmd      o_cmd
);

    tcw_pkg::t_kind w_kind;

    always_comb begin
        unique case (i_cmd)
            tcw_pkg::CMD_PUT:    w_kind = (i_char_code == tcw_pkg::NEWLINE_CODE) ?
                                          tcw_pkg::K_NEWLINE : tcw_pkg::K_PUT;
            tcw_pkg::CMD_SETCUR: w_kind = tcw_pkg::K_SETCUR;
            tcw_pkg::CMD_CLEAR:  w_kind = tcw_pkg::K_CLEAR;
            tcw_pkg::CMD_READ:   w_kind = tcw_pkg::K_READ;
            default:             w_kind = tcw_pkg::K_READ;
        endcase
    end

    assign o_ready = !i_full && !i_hold;
    assign o_push  = i_valid && o_ready;

    assign o_cmd.kind      = w_kind;
    assign o_cmd.char_code = i_char_code;
    assign o_cmd.attr      = i_attr;
    assign o_cmd.col       = (i_col >= 8'(COLUMNS)) ? 8'(COLUMNS - 1) : i_col;
    assign o_cmd.row       = (i_row >= 8'(ROWS)) ? 8'(ROWS - 1) : i_row;

endmodule

`default_nettype wire

// File: rtl/tcw_queue.sv
// Short command queue between front and back end.
// Depends on tcw_pkg. DEPTH must be a power of two.
`default_nettype none

module tcw_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tcw_pkg::t_cmd i_data,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output tcw_pkg::t_cmd      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    tcw_pkg::t_cmd   r_slot [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CNTW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = i_push ? r_wptr + PW'(1) : r_wptr;
        n_rptr  = i_pop ? r_rptr + PW'(1) : r_rptr;
        n_count = r_count + CNTW'(i_push) - CNTW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];

endmodule

`default_nettype wire

// File: rtl/tcw_back.sv
// Back end: cursor, screen store, clear and scroll sweeps, result register.
// Depends on tcw_pkg, tcw_ram and the assertion macro header.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire tcw_pkg::t_cmd i_head,
    output logic               o_pop,
    output logic               o_init_busy,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_cell_char,
    output logic [7:0]         o_cell_attr,
    output logic [6:0]         o_cursor_col,
    output logic [4:0]         o_cursor_row
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_x, n_x;
    logic [RW-1:0] r_y, n_y;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_clr_reply, n_clr_reply;
    logic          r_wb_valid, n_wb_valid;
    logic          r_wb_blank, n_wb_blank;
    logic [AW-1:0] r_wb_addr, n_wb_addr;
    logic          r_out_valid;
    logic [7:0]    r_out_char, r_out_attr;
    logic [6:0]    r_out_col;
    logic [4:0]    r_out_row;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic          load_out;
    logic [7:0]    ld_char, ld_attr;
    logic [AW-1:0] cur_idx;
    logic          x_wrap, y_last, slot_free;
    logic          cursor_ok;

    assign cur_idx   = AW'(r_y * COLUMNS + r_x);
    assign x_wrap    = ((CW+1)'(r_x) + (CW+1)'(1)) >= (CW+1)'(COLUMNS);
    assign y_last    = ((RW+1)'(r_y) + (RW+1)'(1)) >= (RW+1)'(ROWS);
    assign slot_free = !r_out_valid || i_out_ready;
    assign cursor_ok = ((CW+1)'(r_x) < (CW+1)'(COLUMNS)) && ((RW+1)'(r_y) < (RW+1)'(ROWS));

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_cnt       = r_cnt;
        n_clr_reply = r_clr_reply;
        n_wb_valid  = 1'b0;
        n_wb_blank  = r_wb_blank;
        n_wb_addr   = r_wb_addr;
        ram_we      = 1'b0;
        ram_waddr   = cur_idx;
        ram_wdata   = tcw_pkg::BLANK_CELL;
        ram_re      = 1'b0;
        ram_raddr   = cur_idx;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        ld_char     = '0;
        ld_attr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && slot_free) begin
                    o_pop = 1'b1;
                    unique case (i_head.kind)
                        tcw_pkg::K_PUT, tcw_pkg::K_NEWLINE: begin
                            if (i_head.kind == tcw_pkg::K_PUT) begin
                                ram_we    = 1'b1;
                                ram_wdata = {i_head.attr, i_head.char_code};
                            end
                            if (i_head.kind == tcw_pkg::K_PUT && !x_wrap) begin
                                n_x      = r_x + CW'(1);
                                load_out = 1'b1;
                            end else begin
                                // next line, scrolling when on the bottom row
                                n_x = '0;
                                if (y_last) begin
                                    n_y     = RW'(ROWS - 1);
                                    n_cnt   = '0;
                                    n_state = ST_SCROLL;
                                end else begin
                                    n_y      = r_y + RW'(1);
                                    load_out = 1'b1;
                                end
                            end
                        end
                        tcw_pkg::K_SETCUR: begin
                            n_x      = CW'(i_head.col);
                            n_y      = RW'(i_head.row);
                            load_out = 1'b1;
                        end
                        tcw_pkg::K_CLEAR: begin
                            n_cnt       = '0;
                            n_clr_reply = 1'b1;
                            n_state     = ST_CLEAR;
                        end
                        tcw_pkg::K_READ: begin
                            ram_re  = 1'b1;
                            n_state = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                load_out = 1'b1;
                ld_char  = ram_rdata[7:0];
                ld_attr  = ram_rdata[15:8];
                n_state  = ST_IDLE;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt       = '0;
                    n_state     = ST_IDLE;
                    load_out    = r_clr_reply;
                    n_clr_reply = 1'b0;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_SCROLL: begin
                // read one row below, write it in the following cycle; last row gets blanks
                ram_re     = (r_cnt < AW'(CELLS - COLUMNS));
                ram_raddr  = r_cnt + AW'(COLUMNS);
                n_wb_valid = 1'b1;
                n_wb_addr  = r_cnt;
                n_wb_blank = !ram_re;
                ram_we     = r_wb_valid;
                ram_waddr  = r_wb_addr;
                ram_wdata  = r_wb_blank ? tcw_pkg::BLANK_CELL : ram_rdata;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_DRAIN: begin
                ram_we    = r_wb_valid;
                ram_waddr = r_wb_addr;
                ram_wdata = r_wb_blank ? tcw_pkg::BLANK_CELL : ram_rdata;
                load_out  = 1'b1;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_x         <= '0;
            r_y         <= '0;
            r_cnt       <= '0;
            r_clr_reply <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_cnt       <= n_cnt;
            r_clr_reply <= n_clr_reply;
            r_wb_valid  <= n_wb_valid;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr  <= n_wb_addr;
        r_wb_blank <= n_wb_blank;
        if (load_out) begin
            r_out_char <= ld_char;
            r_out_attr <= ld_attr;
            r_out_col  <= 7'(n_x);
            r_out_row  <= 5'(n_y);
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_init_busy  = (r_state == ST_CLEAR) && !r_clr_reply;
    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;

    `TCW_ASSERT_IMP(a_load_into_free_slot, i_clk, i_rst_n, load_out, slot_free)
    `TCW_ASSERT_IMP(a_cursor_in_range, i_clk, i_rst_n, 1'b1, cursor_ok)
    `TCW_ASSERT_IMP(a_scroll_reads_ahead, i_clk, i_rst_n, (r_state == ST_SCROLL) && ram_we && ram_re, ram_raddr > ram_waddr)
    `TCW_ASSERT_NXT(a_pop_leaves_work, i_clk, i_rst_n, o_pop, (r_state != ST_IDLE) || r_out_valid)

endmodule

`default_nettype wire

// File: rtl/text_console_writer_unit.sv
// Text console writer: a COLUMNS x ROWS character/attribute screen store and cursor.
//
// Input stream: tuser carries the command (put, set cursor, clear, read), tdata the
// character, attribute, column and row. Each accepted command yields exactly one
// result on the output stream: the cell under the cursor (read only, else zero)
// and the cursor position after the command.
// A front end classifies commands into a two-entry queue; the back end executes
// them from the queue, so input keeps flowing while a result waits for the sink.
// A command passes the queue and then the result register; a read also passes the
// registered store read, and clear and a put or newline that scrolls first sweep the
// store (one cell per cycle). The back end takes one put, newline or set cursor per
// cycle while the sink takes each result and no scroll occurs; a read, a clear or a
// scroll holds off the next command until it is done.
// Reset: synchronous active-low. After reset a clearing pass writes spaces with
// black attribute to every cell, while s_axis_tready stays low. The cursor
// resets to the top-left cell.
// A stalled sink holds the result register; the back end then takes no command
// and the queue fills, after which s_axis_tready drops.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back, tcw_ram.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // char_code, attr, col, row
    input  wire logic [1:0]  s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // cell_char, cell_attr, cursor_col, cursor_row, pad
);

    tcw_pkg::t_cmd w_push_cmd;
    tcw_pkg::t_cmd w_head;
    logic          w_push, w_pop, w_full, w_empty, w_init_busy;
    logic [7:0]    w_cell_char, w_cell_attr;
    logic [6:0]    w_cursor_col;
    logic [4:0]    w_cursor_row;

    tcw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_char_code(s_axis_tdata[7:0]),
        .i_attr     (s_axis_tdata[15:8]),
        .i_col      (s_axis_tdata[23:16]),
        .i_row      (s_axis_tdata[31:24]),
        .i_full     (w_full),
        .i_hold     (w_init_busy),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    tcw_queue #(
        .DEPTH(2)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_cmd),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_empty(w_empty),
        .o_head (w_head)
    );

    tcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cell_char (w_cell_char),
        .o_cell_attr (w_cell_attr),
        .o_cursor_col(w_cursor_col),
        .o_cursor_row(w_cursor_row)
    );

    assign m_axis_tdata = {4'b0000, w_cursor_row, w_cursor_col, w_cell_attr, w_cell_char};

endmodule

`default_nettype wire

// File: verif/tcw_checker.sv
// Checker for the text console writer: watches both stream channels, keeps its own
// screen store and cursor, and compares every result transaction with its prediction.
// Depends on tcw_pkg for command codes and cell constants.
`timescale 1ns / 100ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code, attr, col, row
    input  logic [1:0]  s_axis_tuser,   // cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // cell_char, cell_attr, cursor_col, cursor_row, pad
    output int          o_fail_count,
    output int          o_pending
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
    } t_console_report;

    logic [15:0]     screen [CELLS];
    logic [7:0]      cur_col;
    logic [7:0]      cur_row;
    t_console_report pending_reports[$];
    int              fails = 0;

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen[i] = tcw_pkg::BLANK_CELL;
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = tcw_pkg::BLANK_CELL;
    endfunction

    // column 0 of the next row; scrolls when already on the last row
    function automatic void next_row();
        cur_col = '0;
        if (int'(cur_row) + 1 >= ROWS) begin
            scroll_screen();
            cur_row = 8'(ROWS - 1);
        end else begin
            cur_row = cur_row + 8'd1;
        end
    endfunction

    function automatic t_console_report apply_console_cmd(logic [1:0] cmd, logic [31:0] data);
        logic [7:0]      code;
        logic [7:0]      attr;
        logic [7:0]      col;
        logic [7:0]      row;
        int              idx;
        t_console_report rep;
        code = data[7:0];
        attr = data[15:8];
        col  = data[23:16];
        row  = data[31:24];
        rep  = '0;
        idx  = int'(cur_row) * COLUMNS + int'(cur_col);
        case (cmd)
            tcw_pkg::CMD_PUT: begin
                if (code == tcw_pkg::NEWLINE_CODE) begin
                    next_row();
                end else begin
                    screen[idx] = {attr, code};
                    if (int'(cur_col) + 1 >= COLUMNS) next_row();
                    else cur_col = cur_col + 8'd1;
                end
            end
            tcw_pkg::CMD_SETCUR: begin
                cur_col = (int'(col) >= COLUMNS) ? 8'(COLUMNS - 1) : col;
                cur_row = (int'(row) >= ROWS) ? 8'(ROWS - 1) : row;
            end
            tcw_pkg::CMD_CLEAR: blank_screen();
            tcw_pkg::CMD_READ: begin
                rep.cell_char = screen[idx][7:0];
                rep.cell_attr = screen[idx][15:8];
            end
            default: ;
        endcase
        rep.cursor_col = cur_col[6:0];
        rep.cursor_row = cur_row[4:0];
        return rep;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    function automatic void check_report(logic [31:0] data);
        t_console_report want;
        if (pending_reports.size() == 0) begin
            $error("result transaction with nothing expected, tdata %h", data);
            fails++;
        end else begin
            want = pending_reports.pop_front();
            check_field("cell_char", want.cell_char, data[7:0]);
            check_field("cell_attr", want.cell_attr, data[15:8]);
            check_field("cursor_col", want.cursor_col, data[22:16]);
            check_field("cursor_row", want.cursor_row, data[27:23]);
            check_field("pad", 0, data[31:28]);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blank_screen();
            cur_col = '0;
            cur_row = '0;
            pending_reports.delete();
        end else begin
            // a result never shares an edge with its own command
            if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                pending_reports.push_back(apply_console_cmd(s_axis_tuser, s_axis_tdata));
        end
        o_fail_count <= fails;
        o_pending    <= pending_reports.size();
    end

endmodule

// File: verif/tb_top.sv
// Top of the text console writer testbench: clock, reset, command stimulus and
// receiver stalls. Instantiates text_console_writer_unit and tcw_checker; uses tcw_pkg.
`timescale 1ns / 100ps

module tb_top;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 1850;
    localparam int MAX_GAP    = 8;
    localparam int MAX_STALL  = 6;
    localparam int MAX_CYCLES = (N_DIRECTED + N_RANDOM)
                                * (COLUMNS * ROWS + 8 + MAX_GAP + MAX_STALL) * 3
                                + COLUMNS * ROWS;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // char_code, attr, col, row
    logic [1:0]  s_axis_tuser  = '0;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // cell_char, cell_attr, cursor_col, cursor_row, pad

    int       fail_count;
    int       pending;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    t_rx_mode rx_mode      = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_stall     = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    text_console_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tcw_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // one command transaction; the sender may idle between bursts of random length
    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] code,
                            input logic [7:0] attr, input logic [7:0] col,
                            input logic [7:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {row, col, attr, code};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // receiver: switches between always ready, random ready and stall runs
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 400);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 9) < 6);
            default: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 4) == 0) rx_stall = $urandom_range(1, MAX_STALL);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        logic [1:0] cmd;
        logic [7:0] code;
        logic [7:0] attr;
        logic [7:0] col;
        logic [7:0] row;
        int         pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: blank read, extremes, wraps, scrolls, saturation, clear
        send_cmd(tcw_pkg::CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tcw_pkg::CMD_PUT,    8'h00, 8'h00, 8'hFF, 8'hFF);
        send_cmd(tcw_pkg::CMD_PUT,    8'hFF, 8'hFF, 8'h00, 8'h00);
        send_cmd(tcw_pkg::CMD_PUT,    tcw_pkg::NEWLINE_CODE, 8'hFF, 8'h12, 8'h34);
        send_cmd(tcw_pkg::CMD_SETCUR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(tcw_pkg::CMD_PUT,    8'h41, 8'h1F, 8'h00, 8'h00);  // last cell: wrap plus scroll
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd79, 8'd23);
        send_cmd(tcw_pkg::CMD_READ,   8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd80, 8'd25);
        send_cmd(tcw_pkg::CMD_PUT,    tcw_pkg::NEWLINE_CODE, 8'h00, 8'h00, 8'h00);  // last row
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd79, 8'd22);
        send_cmd(tcw_pkg::CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd78, 8'd3);
        send_cmd(tcw_pkg::CMD_PUT,    8'h55, 8'hAA, 8'h55, 8'hAA);
        send_cmd(tcw_pkg::CMD_PUT,    8'hAA, 8'h55, 8'hAA, 8'h55);  // row wrap without scroll
        send_cmd(tcw_pkg::CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(tcw_pkg::CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tcw_pkg::CMD_CLEAR,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd78, 8'd3);
        send_cmd(tcw_pkg::CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd0, 8'd24);
        send_cmd(tcw_pkg::CMD_PUT,    8'h7F, 8'h80, 8'h80, 8'h7F);
        send_cmd(tcw_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'd0, 8'd24);
        send_cmd(tcw_pkg::CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00);

        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            code = 8'($urandom);
            attr = 8'($urandom);
            col  = 8'($urandom);
            row  = 8'($urandom);
            if (pick < 50) begin
                cmd = tcw_pkg::CMD_PUT;
            end else if (pick < 57) begin
                cmd  = tcw_pkg::CMD_PUT;
                code = tcw_pkg::NEWLINE_CODE;
            end else if (pick < 72) begin
                cmd = tcw_pkg::CMD_SETCUR;
                // mostly on screen; the rest saturates, often onto the last row
                if ($urandom_range(0, 6) != 0) begin
                    col = 8'($urandom_range(0, COLUMNS - 1));
                    row = 8'($urandom_range(0, ROWS - 1));
                end
            end else if (pick < 73) begin
                cmd = tcw_pkg::CMD_CLEAR;
            end else begin
                cmd = tcw_pkg::CMD_READ;
            end
            if (n == N_RANDOM / 2) wait_drained();
            send_cmd(cmd, code, attr, col, row);
        end

        wait_drained();
        repeat (COLUMNS * ROWS + 8) @(posedge i_clk);
        if (fail_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: text_console_writer_unit.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer_unit.sv
verif/tcw_checker.sv
verif/tb_top.sv
